FILE: rtl/clpg_pkg.sv
// shared constants and types for the clamped line pixel generator
`default_nettype none
package clpg_pkg;

	localparam int DEF_SCREEN_WIDTH  = 320;
	localparam int DEF_SCREEN_HEIGHT = 200;
	localparam int DEF_COORD_BITS    = 11;

	localparam int IN_COORD_W = 11;
	localparam int DELTA_W    = 12;
	localparam int COLOR_W    = 8;
	localparam int ADDR_W     = 16;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// status of the pixel waiting between the stepper and the output stage
	typedef struct packed {
		logic valid;
		logic last;
	} clpg_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/clpg_step.sv
// line state: endpoint setup on start, error accumulator and axis moves on step
`default_nettype none
module clpg_step #(
	parameter int COORD_BITS = clpg_pkg::DEF_COORD_BITS
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire logic                                    opcode,
	input  wire logic signed [clpg_pkg::IN_COORD_W-1:0]  start_x,
	input  wire logic signed [clpg_pkg::IN_COORD_W-1:0]  start_y,
	input  wire logic signed [clpg_pkg::IN_COORD_W-1:0]  end_x,
	input  wire logic signed [clpg_pkg::IN_COORD_W-1:0]  end_y,
	input  wire logic        [clpg_pkg::COLOR_W-1:0]     pixel_color,
	input  wire logic                                    advance,
	output clpg_pkg::clpg_ctl_t                          ctl,
	output logic             [COORD_BITS-1:0]            cur_x,
	output logic             [COORD_BITS-1:0]            cur_y,
	output logic             [clpg_pkg::COLOR_W-1:0]     line_color
);

	localparam int DW = clpg_pkg::DELTA_W;

	logic                  busy_q, busy_d;
	logic [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
	logic [DW-1:0]         err_q, err_d, major_q, major_d, minor_q, minor_d;
	logic [DW-1:0]         steps_q, steps_d;
	logic                  x_major_q, x_major_d;
	logic [1:0]            dir_x_q, dir_x_d, dir_y_q, dir_y_d;
	logic [clpg_pkg::COLOR_W-1:0] color_q, color_d;
	clpg_pkg::clpg_ctl_t   ctl_s1, ctl_d;

	logic                  accept;
	logic signed [DW-1:0]  dx, dy;
	logic        [DW-1:0]  ax, ay;
	logic signed [31:0]    x1_ext, y1_ext;
	logic        [DW-1:0]  err_sum;
	logic                  minor_step;
	logic [COORD_BITS-1:0] step_x, step_y;

	assign in_ready = !ctl_s1.valid || advance;
	assign accept   = in_valid && in_ready;

	assign dx = DW'(end_x) - DW'(start_x);
	assign dy = DW'(end_y) - DW'(start_y);
	assign ax = dx[DW-1] ? -dx : dx;
	assign ay = dy[DW-1] ? -dy : dy;
	assign x1_ext = start_x;
	assign y1_ext = start_y;

	// error accumulator stays below the major delta, so the sum fits
	assign err_sum    = err_q + minor_q;
	assign minor_step = err_sum >= major_q;
	assign step_x     = {{(COORD_BITS-2){dir_x_q[1]}}, dir_x_q};
	assign step_y     = {{(COORD_BITS-2){dir_y_q[1]}}, dir_y_q};

	always_comb begin
		busy_d    = busy_q;
		cur_x_d   = cur_x_q;
		cur_y_d   = cur_y_q;
		err_d     = err_q;
		major_d   = major_q;
		minor_d   = minor_q;
		steps_d   = steps_q;
		x_major_d = x_major_q;
		dir_x_d   = dir_x_q;
		dir_y_d   = dir_y_q;
		color_d   = color_q;
		ctl_d     = ctl_s1;
		if (advance) begin
			ctl_d.valid = 1'b0;
		end
		if (accept) begin
			if (opcode == clpg_pkg::OP_START) begin
				dir_x_d   = dx[DW-1] ? 2'b11 : ((dx != '0) ? 2'b01 : 2'b00);
				dir_y_d   = dy[DW-1] ? 2'b11 : ((dy != '0) ? 2'b01 : 2'b00);
				cur_x_d   = x1_ext[COORD_BITS-1:0];
				cur_y_d   = y1_ext[COORD_BITS-1:0];
				color_d   = pixel_color;
				x_major_d = ax >= ay;
				major_d   = (ax >= ay) ? ax : ay;
				minor_d   = (ax >= ay) ? ay : ax;
				err_d     = '0;
				steps_d   = (ax >= ay) ? ax : ay;
				busy_d    = steps_d != '0;
				ctl_d.valid = 1'b1;
				ctl_d.last  = !busy_d;
			end else if (busy_q) begin
				err_d = minor_step ? err_sum - major_q : err_sum;
				if (x_major_q) begin
					cur_x_d = cur_x_q + step_x;
					cur_y_d = minor_step ? cur_y_q + step_y : cur_y_q;
				end else begin
					cur_y_d = cur_y_q + step_y;
					cur_x_d = minor_step ? cur_x_q + step_x : cur_x_q;
				end
				steps_d = steps_q - 1'b1;
				busy_d  = steps_d != '0;
				ctl_d.valid = 1'b1;
				ctl_d.last  = !busy_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			err_q     <= '0;
			major_q   <= '0;
			minor_q   <= '0;
			steps_q   <= '0;
			x_major_q <= 1'b0;
			dir_x_q   <= '0;
			dir_y_q   <= '0;
			color_q   <= '0;
			ctl_s1    <= '0;
		end else begin
			busy_q    <= busy_d;
			cur_x_q   <= cur_x_d;
			cur_y_q   <= cur_y_d;
			err_q     <= err_d;
			major_q   <= major_d;
			minor_q   <= minor_d;
			steps_q   <= steps_d;
			x_major_q <= x_major_d;
			dir_x_q   <= dir_x_d;
			dir_y_q   <= dir_y_d;
			color_q   <= color_d;
			ctl_s1    <= ctl_d;
		end
	end

	assign ctl        = ctl_s1;
	assign cur_x      = cur_x_q;
	assign cur_y      = cur_y_q;
	assign line_color = color_q;

endmodule
`default_nettype wire

FILE: rtl/clpg_emit.sv
// coordinate clamp, address multiply and output register
`default_nettype none
module clpg_emit #(
	parameter int SCREEN_WIDTH  = clpg_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = clpg_pkg::DEF_SCREEN_HEIGHT,
	parameter int COORD_BITS    = clpg_pkg::DEF_COORD_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire clpg_pkg::clpg_ctl_t                 ctl,
	output logic                                     advance,
	input  wire logic [COORD_BITS-1:0]               cur_x,
	input  wire logic [COORD_BITS-1:0]               cur_y,
	input  wire logic [clpg_pkg::COLOR_W-1:0]        line_color,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [clpg_pkg::ADDR_W-1:0]              pixel_address,
	output logic [clpg_pkg::COLOR_W-1:0]             pixel_value,
	output logic                                     last_pixel
);

	localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
	localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

	logic [31:0]                   xu, yu, addr_full;
	logic [XW-1:0]                 px;
	logic [YW-1:0]                 py;
	logic                          out_valid_s2;
	logic [clpg_pkg::ADDR_W-1:0]   addr_s2;
	logic [clpg_pkg::COLOR_W-1:0]  value_s2;
	logic                          last_s2;

	assign advance = ctl.valid && (!out_valid_s2 || out_ready);

	assign xu = 32'(cur_x);
	assign yu = 32'(cur_y);

	// negative or past the edge goes to the last column or row
	assign px = (cur_x[COORD_BITS-1] || xu > 32'(SCREEN_WIDTH - 1))
		? XW'(SCREEN_WIDTH - 1) : xu[XW-1:0];
	assign py = (cur_y[COORD_BITS-1] || yu > 32'(SCREEN_HEIGHT - 1))
		? YW'(SCREEN_HEIGHT - 1) : yu[YW-1:0];

	assign addr_full = 32'(py) * 32'(SCREEN_WIDTH) + 32'(px);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			addr_s2  <= addr_full[clpg_pkg::ADDR_W-1:0];
			value_s2 <= line_color;
			last_s2  <= ctl.last;
		end
	end

	assign out_valid     = out_valid_s2;
	assign pixel_address = addr_s2;
	assign pixel_value   = value_s2;
	assign last_pixel    = last_s2;

endmodule
`default_nettype wire

FILE: rtl/clamped_line_pixel_generator_core.sv
// Line pixel generator: start and step commands in, clamped frame buffer pixels out.
//
// Input stream: s_axis_tuser carries the command (start a line or step along it),
// s_axis_tdata the two endpoints and the color, used on start only. A start gives
// the first pixel right away; each step after it gives the next pixel, with
// m_axis_tlast marking the line's final one. A step with no line in progress is
// taken and dropped, a start in the middle of a line abandons it.
// Output stream: m_axis_tdata carries the byte address clamp(y)*width+clamp(x)
// and the color. Off-screen coordinates are pulled to the last column or row.
// An accepted item passes the line state register, updated with the error add,
// compare and subtract, and then the output register, after the clamp and constant
// multiply; one item per cycle is sustained while m_axis_tready stays high.
// A stalled receiver backs up through the output register and a one-deep pixel
// stage into s_axis_tready. Reset clears the line state and drops both stages;
// the block is idle, with no line in progress, afterwards.
`default_nettype none
module clamped_line_pixel_generator_core #(
	parameter int SCREEN_WIDTH  = clpg_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = clpg_pkg::DEF_SCREEN_HEIGHT,
	parameter int COORD_BITS    = clpg_pkg::DEF_COORD_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// start_x, start_y, end_x, end_y, pixel_color, zero fill
	input  wire logic [clpg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// opcode
	input  wire logic [0:0]                         s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// pixel_address, pixel_value
	output logic [clpg_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	output logic                                    m_axis_tlast
);

	localparam int CW = clpg_pkg::IN_COORD_W;
	localparam int KW = clpg_pkg::COLOR_W;
	localparam int AW = clpg_pkg::ADDR_W;

	clpg_pkg::clpg_ctl_t  ctl;
	logic                 advance;
	logic [COORD_BITS-1:0] cur_x, cur_y;
	logic [KW-1:0]        line_color;
	logic [AW-1:0]        pixel_address;
	logic [KW-1:0]        pixel_value;

	clpg_step #(
		.COORD_BITS (COORD_BITS)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.opcode      (s_axis_tuser[0]),
		.start_x     (s_axis_tdata[CW-1:0]),
		.start_y     (s_axis_tdata[2*CW-1:CW]),
		.end_x       (s_axis_tdata[3*CW-1:2*CW]),
		.end_y       (s_axis_tdata[4*CW-1:3*CW]),
		.pixel_color (s_axis_tdata[4*CW+KW-1:4*CW]),
		.advance     (advance),
		.ctl         (ctl),
		.cur_x       (cur_x),
		.cur_y       (cur_y),
		.line_color  (line_color)
	);

	clpg_emit #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.COORD_BITS    (COORD_BITS)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.advance       (advance),
		.cur_x         (cur_x),
		.cur_y         (cur_y),
		.line_color    (line_color),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value),
		.last_pixel    (m_axis_tlast)
	);

	assign m_axis_tdata = {pixel_value, pixel_address};

`ifndef NO_ASSERTIONS
	// a pending pixel that cannot move on must block new items
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.valid && !advance) |-> !s_axis_tready)
		else $error("pixel stage overwritten while stalled");

	// every accepted start produces a pixel next cycle
	a_start_gives_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == clpg_pkg::OP_START)
		|=> ctl.valid)
		else $error("start item produced no pixel");

	// clamped address stays inside the frame when the frame fits the address
	a_addr_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(pixel_address) < 32'(SCREEN_WIDTH * SCREEN_HEIGHT)
		|| SCREEN_WIDTH * SCREEN_HEIGHT > 65536))
		else $error("pixel address outside the frame");
`endif

endmodule
`default_nettype wire
